// ===== hw/rtl/vgrm_pkg.sv =====
// Shared types and constants of the voxel grid running mean block.
// No dependencies; every other file refers to it by scoped names.
package vgrm_pkg;

  // Default grid edge in cells
  localparam int GRID_SIZE_DEF = 64;

  // Field widths
  localparam int POS_W = 24;
  localparam int COL_W = 8;
  localparam int HIT_W = 16;
  localparam int CPM_W = 20;
  localparam int CUT_W = 16;
  localparam int IDX_IN_W = 8;
  localparam int ADDR_MAX_W = 24;

  // Position times scale: 24 signed by 21 signed, 24 fraction bits dropped
  localparam int PROD_W = 45;
  localparam int FRAC_SHIFT = 24;

  // Configuration
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_CPM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WHITE = 2'd2;
  localparam logic [CPM_W-1:0] CPM_RESET = 20'd25600;
  localparam logic [CUT_W-1:0] CUTOFF_RESET = 16'd10;
  localparam logic [COL_W-1:0] WHITE_RESET = 8'd210;

  localparam logic [HIT_W-1:0] HIT_MAX = 16'hFFFF;

  // Item modes
  localparam logic MODE_ADD = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Divider: three position lanes, three colour lanes
  localparam int DIV_LANES = 6;
  localparam int DIV_W = 25;
  localparam int DIV_CNT_W = 5;

  localparam int QUEUE_DEPTH = 2;

  // Classified item between front and back
  typedef struct packed {
    logic mode;
    logic in_range;
    logic [ADDR_MAX_W-1:0] addr;
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [POS_W-1:0] pz;
    logic [COL_W-1:0] r;
    logic [COL_W-1:0] g;
    logic [COL_W-1:0] b;
  } vgrm_op_t;

  // One cell of the store
  typedef struct packed {
    logic signed [POS_W-1:0] mx;
    logic signed [POS_W-1:0] my;
    logic signed [POS_W-1:0] mz;
    logic [COL_W-1:0] r;
    logic [COL_W-1:0] g;
    logic [COL_W-1:0] b;
    logic [HIT_W-1:0] hits;
  } vgrm_cell_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_RESULT
  } vgrm_state_t;

endpackage

// ===== hw/rtl/vgrm_queue.sv =====
// Two-entry queue of classified items between front and back.
// Depends on vgrm_pkg.
module vgrm_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  vgrm_pkg::vgrm_op_t wr_data,
  output logic              full,
  input  logic              rd,
  output vgrm_pkg::vgrm_op_t rd_data,
  output logic              empty
);
  localparam int PW = $clog2(vgrm_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(vgrm_pkg::QUEUE_DEPTH + 1);

  vgrm_pkg::vgrm_op_t slots [vgrm_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full = (count == CW'(vgrm_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign rd_data = slots[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (wr && !full) wr_ptr <= wr_ptr + 1'b1;
      if (rd && !empty) rd_ptr <= rd_ptr + 1'b1;
      count <= count + CW'(wr && !full) - CW'(rd && !empty);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (wr && !full) slots[wr_ptr] <= wr_data;
  end
endmodule

// ===== hw/rtl/vgrm_front.sv =====
// Front end: takes items, scales positions to cell indices, checks range,
// forms the cell address and hands the item to the queue. Depends on vgrm_pkg.
module vgrm_front #(
  parameter int GRID_SIZE = vgrm_pkg::GRID_SIZE_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic                              hold,
  input  logic                              mode,
  input  logic signed [vgrm_pkg::POS_W-1:0] pos_x,
  input  logic signed [vgrm_pkg::POS_W-1:0] pos_y,
  input  logic signed [vgrm_pkg::POS_W-1:0] pos_z,
  input  logic [vgrm_pkg::COL_W-1:0]        red_in,
  input  logic [vgrm_pkg::COL_W-1:0]        green_in,
  input  logic [vgrm_pkg::COL_W-1:0]        blue_in,
  input  logic [vgrm_pkg::IDX_IN_W-1:0]     cell_x,
  input  logic [vgrm_pkg::IDX_IN_W-1:0]     cell_y,
  input  logic [vgrm_pkg::IDX_IN_W-1:0]     cell_z,
  input  logic [vgrm_pkg::CPM_W-1:0]        cells_per_meter,
  output logic                              q_push,
  output vgrm_pkg::vgrm_op_t                q_entry,
  input  logic                              q_full
);
  localparam int IW = $clog2(GRID_SIZE);
  localparam int HALF = GRID_SIZE / 2;
  localparam int PW = vgrm_pkg::PROD_W;
  localparam int QW = vgrm_pkg::PROD_W - vgrm_pkg::FRAC_SHIFT;
  localparam int AW = vgrm_pkg::ADDR_MAX_W;

  logic s_valid;
  logic s_valid_next;
  logic s_mode;
  logic signed [PW-1:0] s_prod [3];
  logic [vgrm_pkg::IDX_IN_W-1:0] s_cell [3];
  logic signed [vgrm_pkg::POS_W-1:0] s_pos [3];
  logic [vgrm_pkg::COL_W-1:0] s_col [3];
  logic accept;
  logic [2:0] ax_ok;
  logic [IW-1:0] ax_idx [3];
  logic signed [vgrm_pkg::CPM_W:0] scale;

  // Handshake: one stage, drains into the queue
  assign full = hold || (s_valid && q_full);
  assign accept = push && !full;
  assign q_push = s_valid && !q_full;
  assign scale = $signed({1'b0, cells_per_meter});

  always_comb begin
    s_valid_next = s_valid;
    if (accept) s_valid_next = 1'b1;
    else if (q_push) s_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) s_valid <= 1'b0;
    else s_valid <= s_valid_next;
  end

  // Stage register: scaling multiply happens on the way in
  always_ff @(posedge clk) begin
    if (accept) begin
      s_mode <= mode;
      s_prod[0] <= pos_x * scale;
      s_prod[1] <= pos_y * scale;
      s_prod[2] <= pos_z * scale;
      s_cell[0] <= cell_x;
      s_cell[1] <= cell_y;
      s_cell[2] <= cell_z;
      s_pos[0] <= pos_x;
      s_pos[1] <= pos_y;
      s_pos[2] <= pos_z;
      s_col[0] <= red_in;
      s_col[1] <= green_in;
      s_col[2] <= blue_in;
    end
  end

  // Per axis: truncate toward zero, offset by half grid, range check
  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic neg;
    logic [PW-1:0] mag;
    logic [QW-1:0] qmag;
    logic [QW-1:0] pidx;
    logic pos_ok;
    logic cell_ok;
    assign neg = s_prod[a][PW-1];
    assign mag = neg ? $unsigned(-s_prod[a]) : $unsigned(s_prod[a]);
    assign qmag = mag[PW-1:vgrm_pkg::FRAC_SHIFT];
    assign pos_ok = neg ? (qmag <= QW'(HALF)) : (qmag < QW'(GRID_SIZE - HALF));
    assign pidx = neg ? (QW'(HALF) - qmag) : (QW'(HALF) + qmag);
    assign cell_ok = ({1'b0, s_cell[a]} < (vgrm_pkg::IDX_IN_W + 1)'(GRID_SIZE));
    assign ax_ok[a] = s_mode ? cell_ok : pos_ok;
    assign ax_idx[a] = s_mode ? s_cell[a][IW-1:0] : pidx[IW-1:0];
  end

  // Item to the queue
  always_comb begin
    q_entry.mode = s_mode;
    q_entry.in_range = &ax_ok;
    q_entry.addr = (AW'(ax_idx[0]) * AW'(GRID_SIZE) + AW'(ax_idx[1])) * AW'(GRID_SIZE)
                   + AW'(ax_idx[2]);
    q_entry.px = s_pos[0];
    q_entry.py = s_pos[1];
    q_entry.pz = s_pos[2];
    q_entry.r = s_col[0];
    q_entry.g = s_col[1];
    q_entry.b = s_col[2];
  end
endmodule

// ===== hw/rtl/vgrm_div.sv =====
// Six-lane restoring divider with one shared divisor, one quotient bit
// per cycle. Depends on vgrm_pkg.
module vgrm_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [vgrm_pkg::DIV_W-1:0]      dividend [vgrm_pkg::DIV_LANES],
  input  logic [vgrm_pkg::HIT_W-1:0]      divisor,
  output logic                            done,
  output logic [vgrm_pkg::DIV_W-1:0]      quotient [vgrm_pkg::DIV_LANES]
);
  localparam int DW = vgrm_pkg::DIV_W;
  localparam int HW = vgrm_pkg::HIT_W;
  localparam int NL = vgrm_pkg::DIV_LANES;
  localparam int CW = vgrm_pkg::DIV_CNT_W;

  logic busy;
  logic [CW-1:0] cnt;
  logic [HW-1:0] dvs;
  logic [HW-1:0] rem [NL];
  logic [DW-1:0] quo [NL];
  logic [HW-1:0] rem_next [NL];
  logic [NL-1:0] qbit;

  assign quotient = quo;

  // One restoring step per lane
  always_comb begin
    for (int l = 0; l < NL; l++) begin
      qbit[l] = ({rem[l], quo[l][DW-1]} >= {1'b0, dvs});
      rem_next[l] = qbit[l] ? HW'({rem[l], quo[l][DW-1]} - {1'b0, dvs})
                            : {rem[l][HW-2:0], quo[l][DW-1]};
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      for (int l = 0; l < NL; l++) begin
        rem[l] <= '0;
        quo[l] <= dividend[l];
      end
    end else if (busy) begin
      for (int l = 0; l < NL; l++) begin
        rem[l] <= rem_next[l];
        quo[l] <= {quo[l][DW-2:0], qbit[l]};
      end
    end
  end
endmodule

// ===== hw/rtl/vgrm_back.sv =====
// Back end: owns the cell store, clears it after reset, runs the read-modify-write of
// each point, reads a query's cell, forms results. Depends on vgrm_pkg, vgrm_div.
module vgrm_back #(
  parameter int GRID_SIZE = vgrm_pkg::GRID_SIZE_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_empty,
  input  vgrm_pkg::vgrm_op_t          q_head,
  output logic                        q_pop,
  output logic                        clearing,
  input  logic [vgrm_pkg::CUT_W-1:0]  cutoff_hits,
  input  logic [vgrm_pkg::COL_W-1:0]  white_level,
  input  logic                        out_free,
  output logic                        res_load,
  output logic                        res_in_range,
  output vgrm_pkg::vgrm_cell_t        res_cell,
  output logic                        res_keep
);
  localparam int CELLS = GRID_SIZE * GRID_SIZE * GRID_SIZE;
  localparam int AW = $clog2(CELLS);
  localparam int DW = vgrm_pkg::DIV_W;
  localparam int NL = vgrm_pkg::DIV_LANES;
  localparam int PSW = vgrm_pkg::POS_W;

  vgrm_pkg::vgrm_state_t state;
  vgrm_pkg::vgrm_state_t state_next;

  vgrm_pkg::vgrm_cell_t mem [CELLS];
  vgrm_pkg::vgrm_cell_t rd_data;
  vgrm_pkg::vgrm_cell_t wr_data;
  vgrm_pkg::vgrm_cell_t cur;
  vgrm_pkg::vgrm_cell_t old;
  vgrm_pkg::vgrm_cell_t upd;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic mem_we;
  logic [AW-1:0] clr_addr;
  logic clr_last;
  vgrm_pkg::vgrm_op_t op;

  logic [vgrm_pkg::HIT_W-1:0] n_new;
  logic [vgrm_pkg::HIT_W-1:0] n_old;
  logic [vgrm_pkg::HIT_W-1:0] n;
  logic [2:0] sgn;
  logic [2:0] sgn_new;
  logic div_start;
  logic div_done;
  logic [DW-1:0] dvd [NL];
  logic [DW-1:0] quo [NL];
  logic signed [DW-1:0] diff [3];
  logic signed [PSW-1:0] pin [3];
  logic signed [PSW-1:0] min [3];
  logic signed [PSW-1:0] mold [3];
  logic signed [PSW-1:0] mout [3];
  logic [vgrm_pkg::COL_W-1:0] cin [3];
  logic [vgrm_pkg::COL_W-1:0] cold [3];
  logic all_white;

  assign clr_last = (clr_addr == AW'(CELLS - 1));
  assign clearing = (state == vgrm_pkg::ST_CLEAR);

  // Cell store, read data registered
  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      vgrm_pkg::ST_CLEAR:  if (clr_last) state_next = vgrm_pkg::ST_IDLE;
      vgrm_pkg::ST_IDLE: begin
        if (!q_empty) state_next = q_head.in_range ? vgrm_pkg::ST_LOAD : vgrm_pkg::ST_RESULT;
      end
      vgrm_pkg::ST_LOAD: begin
        state_next = (op.mode == vgrm_pkg::MODE_QUERY) ? vgrm_pkg::ST_RESULT : vgrm_pkg::ST_DIV;
      end
      vgrm_pkg::ST_DIV:    if (div_done) state_next = vgrm_pkg::ST_RESULT;
      vgrm_pkg::ST_RESULT: if (out_free) state_next = vgrm_pkg::ST_IDLE;
      default:             state_next = vgrm_pkg::ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= vgrm_pkg::ST_CLEAR;
    else state <= state_next;
  end

  // Outputs of the sequencer
  always_comb begin
    q_pop = 1'b0;
    mem_we = 1'b0;
    div_start = 1'b0;
    res_load = 1'b0;
    wr_addr = op.addr[AW-1:0];
    wr_data = upd;
    case (state)
      vgrm_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        wr_addr = clr_addr;
        wr_data = '0;
      end
      vgrm_pkg::ST_IDLE:   q_pop = !q_empty;
      vgrm_pkg::ST_LOAD:   div_start = (op.mode == vgrm_pkg::MODE_ADD);
      vgrm_pkg::ST_DIV:    mem_we = div_done;
      vgrm_pkg::ST_RESULT: res_load = out_free;
      default: ;
    endcase
  end

  assign rd_addr = q_head.addr[AW-1:0];

  // Clearing sweep
  always_ff @(posedge clk) begin
    if (rst) clr_addr <= '0;
    else if (clearing && !clr_last) clr_addr <= clr_addr + 1'b1;
  end

  // Dividends from the stored cell and the new point
  assign pin[0] = op.px;
  assign pin[1] = op.py;
  assign pin[2] = op.pz;
  assign cin[0] = op.r;
  assign cin[1] = op.g;
  assign cin[2] = op.b;
  assign min[0] = rd_data.mx;
  assign min[1] = rd_data.my;
  assign min[2] = rd_data.mz;
  assign cold[0] = rd_data.r;
  assign cold[1] = rd_data.g;
  assign cold[2] = rd_data.b;
  assign n_new = (rd_data.hits == vgrm_pkg::HIT_MAX) ? vgrm_pkg::HIT_MAX : rd_data.hits + 1'b1;
  assign n_old = (rd_data.hits == vgrm_pkg::HIT_MAX) ? vgrm_pkg::HIT_MAX - 1'b1
                                                     : rd_data.hits;
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      diff[a] = DW'(pin[a]) - DW'(min[a]);
      sgn_new[a] = diff[a][DW-1];
      dvd[a] = sgn_new[a] ? $unsigned(-diff[a]) : $unsigned(diff[a]);
      dvd[a + 3] = DW'(cold[a]) * DW'(n_old) + DW'(cin[a]);
    end
  end

  vgrm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dvd),
    .divisor  (n_new),
    .done     (div_done),
    .quotient (quo)
  );

  // Old means of the cell being updated
  assign mold[0] = old.mx;
  assign mold[1] = old.my;
  assign mold[2] = old.mz;

  // Updated cell: mean moves toward the point by the truncated quotient
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      mout[a] = sgn[a] ? PSW'(DW'(mold[a]) - quo[a])
                       : PSW'(DW'(mold[a]) + quo[a]);
    end
    upd.mx = mout[0];
    upd.my = mout[1];
    upd.mz = mout[2];
    upd.r = quo[3][vgrm_pkg::COL_W-1:0];
    upd.g = quo[4][vgrm_pkg::COL_W-1:0];
    upd.b = quo[5][vgrm_pkg::COL_W-1:0];
    upd.hits = n;
  end

  // Item and cell registers
  always_ff @(posedge clk) begin
    if (q_pop) op <= q_head;
    if (state == vgrm_pkg::ST_LOAD) begin
      old <= rd_data;
      cur <= rd_data;
      n <= n_new;
      sgn <= sgn_new;
    end
    if (state == vgrm_pkg::ST_DIV && div_done) cur <= upd;
  end

  // Result and keep flag
  assign res_in_range = op.in_range;
  assign res_cell = op.in_range ? cur : '0;
  assign all_white = (res_cell.r >= white_level) && (res_cell.g >= white_level) &&
                     (res_cell.b >= white_level);
  assign res_keep = (res_cell.hits > cutoff_hits) && !all_white;

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == vgrm_pkg::ST_CLEAR) |-> !q_pop)
    else $error("queue popped during clearing sweep");
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    res_load |-> out_free)
    else $error("result loaded over a waiting result");
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == vgrm_pkg::ST_DIV))
    else $error("divider finished outside the divide step");
  a_write_after_div: assert property (@(posedge clk) disable iff (rst)
    (mem_we && !clearing) |-> div_done)
    else $error("cell written without a finished update");
endmodule

// ===== hw/rtl/voxel_grid_running_mean.sv =====
// Voxel grid with a running mean per cell: top level.
// Path of a query: front stage, queue, IDLE, LOAD, RESULT, output register;
// a point also waits in DIV on the 25-step shared divider; an out-of-range item
// skips LOAD and DIV. One item is in the back end at a time; the next is popped
// once the last result is loaded. Reset: synchronous; afterwards a clearing sweep
// zeroes the GRID_SIZE^3 cells (262144 at the default) while full stays high.
module voxel_grid_running_mean #(
  parameter int GRID_SIZE = vgrm_pkg::GRID_SIZE_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  logic                               mode,
  input  logic signed [vgrm_pkg::POS_W-1:0]  pos_x,
  input  logic signed [vgrm_pkg::POS_W-1:0]  pos_y,
  input  logic signed [vgrm_pkg::POS_W-1:0]  pos_z,
  input  logic [vgrm_pkg::COL_W-1:0]         red_in,
  input  logic [vgrm_pkg::COL_W-1:0]         green_in,
  input  logic [vgrm_pkg::COL_W-1:0]         blue_in,
  input  logic [vgrm_pkg::IDX_IN_W-1:0]      cell_x,
  input  logic [vgrm_pkg::IDX_IN_W-1:0]      cell_y,
  input  logic [vgrm_pkg::IDX_IN_W-1:0]      cell_z,
  output logic                               empty,
  input  logic                               pop,
  output logic                               in_range,
  output logic signed [vgrm_pkg::POS_W-1:0]  mean_x,
  output logic signed [vgrm_pkg::POS_W-1:0]  mean_y,
  output logic signed [vgrm_pkg::POS_W-1:0]  mean_z,
  output logic [vgrm_pkg::COL_W-1:0]         red_out,
  output logic [vgrm_pkg::COL_W-1:0]         green_out,
  output logic [vgrm_pkg::COL_W-1:0]         blue_out,
  output logic [vgrm_pkg::HIT_W-1:0]         hits,
  output logic                               keep,
  input  logic                               wr_en,
  input  logic [vgrm_pkg::CFG_IDX_W-1:0]     wr_index,
  input  logic [vgrm_pkg::CPM_W-1:0]         wr_data
);
  logic [vgrm_pkg::CPM_W-1:0] cells_per_meter;
  logic [vgrm_pkg::CUT_W-1:0] cutoff_hits;
  logic [vgrm_pkg::COL_W-1:0] white_level;

  logic clearing;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  vgrm_pkg::vgrm_op_t q_entry;
  vgrm_pkg::vgrm_op_t q_head;
  logic out_free;
  logic res_load;
  logic res_in_range;
  logic res_keep;
  vgrm_pkg::vgrm_cell_t res_cell;
  logic res_valid;
  logic res_valid_next;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cells_per_meter <= vgrm_pkg::CPM_RESET;
      cutoff_hits <= vgrm_pkg::CUTOFF_RESET;
      white_level <= vgrm_pkg::WHITE_RESET;
    end else if (wr_en) begin
      case (wr_index)
        vgrm_pkg::REG_CPM:    cells_per_meter <= wr_data;
        vgrm_pkg::REG_CUTOFF: cutoff_hits <= wr_data[vgrm_pkg::CUT_W-1:0];
        vgrm_pkg::REG_WHITE:  white_level <= wr_data[vgrm_pkg::COL_W-1:0];
        default: ;
      endcase
    end
  end

  vgrm_front #(.GRID_SIZE(GRID_SIZE)) u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .hold            (clearing),
    .mode            (mode),
    .pos_x           (pos_x),
    .pos_y           (pos_y),
    .pos_z           (pos_z),
    .red_in          (red_in),
    .green_in        (green_in),
    .blue_in         (blue_in),
    .cell_x          (cell_x),
    .cell_y          (cell_y),
    .cell_z          (cell_z),
    .cells_per_meter (cells_per_meter),
    .q_push          (q_push),
    .q_entry         (q_entry),
    .q_full          (q_full)
  );

  vgrm_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_data (q_entry),
    .full    (q_full),
    .rd      (q_pop),
    .rd_data (q_head),
    .empty   (q_empty)
  );

  vgrm_back #(.GRID_SIZE(GRID_SIZE)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .clearing     (clearing),
    .cutoff_hits  (cutoff_hits),
    .white_level  (white_level),
    .out_free     (out_free),
    .res_load     (res_load),
    .res_in_range (res_in_range),
    .res_cell     (res_cell),
    .res_keep     (res_keep)
  );

  // Output register
  assign empty = !res_valid;
  assign out_free = !res_valid || pop;

  always_comb begin
    res_valid_next = res_valid;
    if (res_load) res_valid_next = 1'b1;
    else if (pop) res_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) res_valid <= 1'b0;
    else res_valid <= res_valid_next;
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      in_range <= res_in_range;
      mean_x <= res_cell.mx;
      mean_y <= res_cell.my;
      mean_z <= res_cell.mz;
      red_out <= res_cell.r;
      green_out <= res_cell.g;
      blue_out <= res_cell.b;
      hits <= res_cell.hits;
      keep <= res_keep;
    end
  end
endmodule

// ===== tb/voxel_grid_running_mean_tb.sv =====
// Testbench for voxel_grid_running_mean: directed and random points and queries,
// each result checked against a built-in running-mean predictor of the voxel store.
// Depends on vgrm_pkg and the voxel_grid_running_mean RTL.
module voxel_grid_running_mean_tb;
  localparam int GRID = vgrm_pkg::GRID_SIZE_DEF;
  localparam int CYCLE_LIMIT = 2500000;
  localparam int POS_W = vgrm_pkg::POS_W;
  localparam int COL_W = vgrm_pkg::COL_W;
  localparam int HIT_W = vgrm_pkg::HIT_W;
  localparam int CPM_W = vgrm_pkg::CPM_W;
  localparam int CUT_W = vgrm_pkg::CUT_W;
  localparam int IDX_IN_W = vgrm_pkg::IDX_IN_W;
  localparam int CFG_IDX_W = vgrm_pkg::CFG_IDX_W;
  localparam int FRAC_SHIFT = vgrm_pkg::FRAC_SHIFT;

  typedef struct {
    logic in_range;
    logic signed [POS_W-1:0] mx;
    logic signed [POS_W-1:0] my;
    logic signed [POS_W-1:0] mz;
    logic [COL_W-1:0] r;
    logic [COL_W-1:0] g;
    logic [COL_W-1:0] b;
    logic [HIT_W-1:0] hits;
    logic keep;
  } cell_view_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic mode = vgrm_pkg::MODE_ADD;
  logic signed [POS_W-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic [COL_W-1:0] red_in = '0, green_in = '0, blue_in = '0;
  logic [IDX_IN_W-1:0] cell_x = '0, cell_y = '0, cell_z = '0;
  logic wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] wr_index = vgrm_pkg::REG_CPM;
  logic [CPM_W-1:0] wr_data = '0;
  logic full, empty, in_range, keep;
  logic signed [POS_W-1:0] mean_x, mean_y, mean_z;
  logic [COL_W-1:0] red_out, green_out, blue_out;
  logic [HIT_W-1:0] hits;

  // Predictor state: sparse copy of the cell store plus registers
  vgrm_pkg::vgrm_cell_t voxel_tab[int];
  logic [CPM_W-1:0] scale_reg = vgrm_pkg::CPM_RESET;
  logic [CUT_W-1:0] cutoff_reg = vgrm_pkg::CUTOFF_RESET;
  logic [COL_W-1:0] white_reg = vgrm_pkg::WHITE_RESET;

  cell_view_t pending_views[$];
  int touched_cells[$];
  logic signed [POS_W-1:0] hot_pos[6][3];
  int fail_count = 0;
  int cycle_count = 0;
  bit steady = 1'b0;  // no idling on either side

  voxel_grid_running_mean dut (.*);

  always #5 clk = ~clk;

  // Timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic longint voxel_axis(logic signed [POS_W-1:0] p);
    longint prod;
    prod = longint'(p) * longint'({1'b0, scale_reg});
    if (prod < 0) return -((-prod) >>> FRAC_SHIFT) + GRID / 2;
    return (prod >>> FRAC_SHIFT) + GRID / 2;
  endfunction

  function automatic logic signed [POS_W-1:0] mean_update(logic signed [POS_W-1:0] m,
      logic signed [POS_W-1:0] p, longint n);
    longint d;
    d = longint'(p) - longint'(m);
    return POS_W'(longint'(m) + d / n);
  endfunction

  // Apply one accepted item to the predictor and queue the cell it reports
  function automatic void predict_cell(logic md, logic signed [POS_W-1:0] px,
      logic signed [POS_W-1:0] py, logic signed [POS_W-1:0] pz,
      logic [COL_W-1:0] cr, logic [COL_W-1:0] cg, logic [COL_W-1:0] cb,
      logic [IDX_IN_W-1:0] qx, logic [IDX_IN_W-1:0] qy, logic [IDX_IN_W-1:0] qz);
    longint ix, iy, iz;
    longint n;
    int addr;
    vgrm_pkg::vgrm_cell_t c;
    cell_view_t v;
    v = '{default: '0};
    if (md == vgrm_pkg::MODE_ADD) begin
      ix = voxel_axis(px); iy = voxel_axis(py); iz = voxel_axis(pz);
    end else begin
      ix = qx; iy = qy; iz = qz;
    end
    if (ix >= 0 && ix < GRID && iy >= 0 && iy < GRID && iz >= 0 && iz < GRID) begin
      addr = int'((ix * GRID + iy) * GRID + iz);
      c = voxel_tab.exists(addr) ? voxel_tab[addr] : '0;
      if (md == vgrm_pkg::MODE_ADD) begin
        if (c.hits != vgrm_pkg::HIT_MAX) c.hits = c.hits + 1'b1;
        n = c.hits;
        c.mx = mean_update(c.mx, px, n);
        c.my = mean_update(c.my, py, n);
        c.mz = mean_update(c.mz, pz, n);
        c.r = COL_W'((longint'(c.r) * (n - 1) + cr) / n);
        c.g = COL_W'((longint'(c.g) * (n - 1) + cg) / n);
        c.b = COL_W'((longint'(c.b) * (n - 1) + cb) / n);
        voxel_tab[addr] = c;
        touched_cells.insert(touched_cells.size(), addr);
      end
      v.in_range = 1'b1;
      v.mx = c.mx; v.my = c.my; v.mz = c.mz;
      v.r = c.r; v.g = c.g; v.b = c.b;
      v.hits = c.hits;
      v.keep = (c.hits > cutoff_reg) &&
               !(c.r >= white_reg && c.g >= white_reg && c.b >= white_reg);
    end
    pending_views.insert(pending_views.size(), v);
  endfunction

  // Send one item, with a random gap before it unless steady
  task automatic send_item(logic md, logic signed [POS_W-1:0] px,
      logic signed [POS_W-1:0] py, logic signed [POS_W-1:0] pz,
      logic [COL_W-1:0] cr, logic [COL_W-1:0] cg, logic [COL_W-1:0] cb,
      logic [IDX_IN_W-1:0] qx, logic [IDX_IN_W-1:0] qy, logic [IDX_IN_W-1:0] qz);
    if (!steady && $urandom_range(99) < 31) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    push <= 1'b1;
    mode <= md;
    pos_x <= px; pos_y <= py; pos_z <= pz;
    red_in <= cr; green_in <= cg; blue_in <= cb;
    cell_x <= qx; cell_y <= qy; cell_z <= qz;
    do @(posedge clk); while (full);
    predict_cell(md, px, py, pz, cr, cg, cb, qx, qy, qz);
  endtask

  task automatic send_point(logic signed [POS_W-1:0] px, logic signed [POS_W-1:0] py,
      logic signed [POS_W-1:0] pz, logic [COL_W-1:0] cr, logic [COL_W-1:0] cg,
      logic [COL_W-1:0] cb);
    send_item(vgrm_pkg::MODE_ADD, px, py, pz, cr, cg, cb,
              IDX_IN_W'($urandom), IDX_IN_W'($urandom), IDX_IN_W'($urandom));
  endtask

  task automatic send_query(logic [IDX_IN_W-1:0] qx, logic [IDX_IN_W-1:0] qy,
      logic [IDX_IN_W-1:0] qz);
    send_item(vgrm_pkg::MODE_QUERY, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
              COL_W'($urandom), COL_W'($urandom), COL_W'($urandom), qx, qy, qz);
  endtask

  // Wait for all results, then let a point still in the divider finish
  task automatic drain;
    push <= 1'b0;
    while (pending_views.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CPM_W-1:0] val);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    case (idx)
      vgrm_pkg::REG_CPM:    scale_reg = val;
      vgrm_pkg::REG_CUTOFF: cutoff_reg = val[CUT_W-1:0];
      vgrm_pkg::REG_WHITE:  white_reg = val[COL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [CPM_W-1:0] scale, logic [CUT_W-1:0] cutoff,
      logic [COL_W-1:0] white);
    drain();
    write_reg(vgrm_pkg::REG_CPM, scale);
    write_reg(vgrm_pkg::REG_CUTOFF, CPM_W'(cutoff));
    write_reg(vgrm_pkg::REG_WHITE, CPM_W'(white));
  endtask

  // Check each popped result against the oldest expectation
  always @(posedge clk) begin
    cell_view_t v;
    if (!rst && pop && !empty) begin
      if (pending_views.size() == 0) begin
        $display("%0t: unexpected result, hits %0d", $time, hits);
        fail_count++;
      end else begin
        v = pending_views.pop_front();
        if (in_range !== v.in_range || mean_x !== v.mx || mean_y !== v.my ||
            mean_z !== v.mz || red_out !== v.r || green_out !== v.g ||
            blue_out !== v.b || hits !== v.hits || keep !== v.keep) begin
          $display("%0t: expected rng %0b m %0d %0d %0d rgb %0d %0d %0d hits %0d keep %0b",
                   $time, v.in_range, v.mx, v.my, v.mz, v.r, v.g, v.b, v.hits, v.keep);
          $display("%0t: actual   rng %0b m %0d %0d %0d rgb %0d %0d %0d hits %0d keep %0b",
                   $time, in_range, mean_x, mean_y, mean_z, red_out, green_out, blue_out,
                   hits, keep);
          fail_count++;
        end
      end
    end
    pop <= steady || ($urandom_range(99) >= 31);
  end

  // Field extremes, centre cell filled past the cutoff, white and dark colours
  task automatic test_directed;
    send_point(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 8'hFF, 8'hFF, 8'hFF);
    send_point(-24'sh800000, -24'sh800000, -24'sh800000, 8'h00, 8'h00, 8'h00);
    for (int i = 0; i < 12; i++)
      send_point(POS_W'(i * 37 - 200), POS_W'(-i * 11), POS_W'(i), 8'hFF, 8'hF0, 8'hD2);
    send_query(8'd32, 8'd32, 8'd32);
    send_point(24'sh000FFF, -24'sh000FFF, 24'sh0, 8'h00, 8'hFF, 8'h00);
    send_query(8'd0, 8'd0, 8'd0);
    send_query(8'd63, 8'd63, 8'd63);
    send_query(8'd64, 8'd0, 8'd0);
    send_query(8'd255, 8'd255, 8'd255);
  endtask

  // Zero, smallest and largest scale
  task automatic test_scale_extremes;
    configure(20'd0, 16'd0, 8'd0);
    send_point(24'sh7FFFFF, -24'sh800000, 24'sh123456, 8'd1, 8'd2, 8'd3);
    send_query(8'd32, 8'd32, 8'd32);
    configure(20'd1, 16'hFFFF, 8'hFF);
    send_point(-24'sh800000, 24'sh7FFFFF, 24'sh0, 8'hFF, 8'hFF, 8'hFF);
    configure(20'hFFFFF, 16'd0, 8'd128);
    send_point(24'sh0001C0, -24'sh0001C0, 24'sh000100, 8'd200, 8'd100, 8'd50);
    send_point(24'sh7FFFFF, 24'sh0, 24'sh0, 8'd0, 8'd0, 8'd0);
  endtask

  function automatic logic signed [POS_W-1:0] pos_near(int span);
    return POS_W'(int'($urandom_range(2 * span)) - span);
  endfunction

  // Random phase: mostly points, half of items near hot spots, queries of filled cells
  task automatic test_random_phase(logic [CPM_W-1:0] scale, logic [CUT_W-1:0] cutoff,
      logic [COL_W-1:0] white, int count, bit no_idle);
    longint span;
    int a, pick;
    configure(scale, cutoff, white);
    span = (scale == 0) ? 64'sd8388607 : (64'sd28 <<< FRAC_SHIFT) / scale;
    if (span > 8388607) span = 8388607;
    foreach (hot_pos[i, j]) hot_pos[i][j] = pos_near(int'(span));
    steady = no_idle;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        a = $urandom_range(5);
        send_point(hot_pos[a][0] + pos_near(31), hot_pos[a][1] + pos_near(31),
                   hot_pos[a][2] + pos_near(31), 8'($urandom_range(150, 255)),
                   8'($urandom_range(150, 255)), 8'($urandom));
      end else if (pick < 65) begin
        send_point(pos_near(int'(span)), pos_near(int'(span)), pos_near(int'(span)),
                   COL_W'($urandom), COL_W'($urandom), COL_W'($urandom));
      end else if (pick < 72) begin
        send_point(POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                   COL_W'($urandom), COL_W'($urandom), COL_W'($urandom));
      end else if (pick < 92 && touched_cells.size() > 0) begin
        a = touched_cells[$urandom_range(touched_cells.size() - 1)];
        send_query(8'(a / (GRID * GRID)), 8'((a / GRID) % GRID), 8'(a % GRID));
      end else begin
        send_query(IDX_IN_W'($urandom), IDX_IN_W'($urandom), IDX_IN_W'($urandom));
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_scale_extremes();
    test_random_phase(20'd25600, 16'd10, 8'd210, 170, 1'b0);
    test_random_phase(20'hFFFFF, 16'd0, 8'hFF, 170, 1'b0);
    test_random_phase(20'd1, 16'hFFFF, 8'd0, 170, 1'b1);
    test_random_phase(20'd300000, 16'd2, 8'd128, 170, 1'b0);
    test_random_phase(20'd25600, 16'd1, 8'd200, 170, 1'b0);
    drain();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
